[rtl/lfr64_pkg.sv]
`default_nettype none

package lfr64_pkg;

    // Operation codes carried in the op field of an input word.
    localparam logic OP_START = 1'b0;
    localparam logic OP_DATA  = 1'b1;

    // Source selects for the output word register.
    localparam logic [1:0] EMIT_NONE  = 2'd0;
    localparam logic [1:0] EMIT_DIGIT = 2'd1;
    localparam logic [1:0] EMIT_DOT   = 2'd2;
    localparam logic [1:0] EMIT_ALPHA = 2'd3;

    // Fixed ASCII codes.
    localparam logic [6:0] CHAR_DOT   = 7'h2e;
    localparam logic [6:0] CHAR_ZERO  = 7'h30;
    localparam logic [6:0] CHAR_UPPER = 7'h40;
    localparam logic [6:0] CHAR_LOWER = 7'h46;
    localparam logic [6:0] CHAR_DIGIT = 7'h05;
    localparam logic [6:0] CHAR_PLUS  = 7'h2b;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       load_start;
        logic       load_data;
        logic       conv_step;
        logic       digit_shift;
        logic [1:0] emit_sel;
        logic       emit_last;
        logic       group_shift;
        logic       close_block;
    } lfr64_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic active;
        logic rem_zero;
        logic cnt_is12;
        logic cnt_is6;
        logic top_zero;
        logic conv_last;
        logic digit_last;
        logic out_free;
    } lfr64_sts_t;

    // Alphabet: '.', 'A'-'Z', 'a'-'z', '0'-'9', '+'.
    function automatic logic [6:0] alpha_char(input logic [5:0] idx);
        logic [6:0] wide_idx;
        logic [6:0] ch;
        wide_idx = {1'b0, idx};
        if (idx == 6'd0)
        begin
            ch = CHAR_DOT;
        end
        else if (idx <= 6'd26)
        begin
            ch = CHAR_UPPER + wide_idx;
        end
        else if (idx <= 6'd52)
        begin
            ch = CHAR_LOWER + wide_idx;
        end
        else if (idx <= 6'd62)
        begin
            ch = wide_idx - CHAR_DIGIT;
        end
        else
        begin
            ch = CHAR_PLUS;
        end
        return ch;
    endfunction

endpackage

`default_nettype wire

[rtl/lfr64_dpath.sv]
`default_nettype none

module lfr64_dpath
    import lfr64_pkg::*;
#(
    parameter int LENGTH_BITS = 24
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic [LENGTH_BITS-1:0] block_length,
    input  wire logic [7:0]             data_byte,
    input  wire logic                   out_stall,
    input  wire lfr64_cmd_t             cmd,
    output lfr64_sts_t                  sts,
    output logic                        out_valid,
    output logic [6:0]                  out_char,
    output logic                        is_last
);

    // Decimal digits needed for the largest length value.
    localparam int NDIG = (LENGTH_BITS * 30103) / 100000 + 1;
    localparam int BCW  = $clog2(LENGTH_BITS + 1);
    localparam int DCW  = $clog2(NDIG + 1);
    localparam int BCDW = NDIG * 4;

    logic [LENGTH_BITS-1:0] bin_reg, bin_next;
    logic [BCDW-1:0]        bcd_reg, bcd_next, bcd_adj;
    logic [BCW-1:0]         bit_cnt_reg, bit_cnt_next;
    logic [DCW-1:0]         dig_cnt_reg, dig_cnt_next;
    logic [11:0]            acc_reg, acc_next;
    logic [3:0]             cnt_reg, cnt_next;
    logic [LENGTH_BITS-1:0] remain_reg, remain_next;
    logic                   active_reg, active_next;
    logic                   out_valid_reg, out_valid_next;
    logic [6:0]             out_char_reg, out_char_next;
    logic                   is_last_reg, is_last_next;
    logic [3:0]             top_digit;

    assign top_digit = bcd_reg[BCDW-1 -: 4];

    // Add-3 correction on every BCD digit before the next shift.
    always_comb
    begin
        logic [3:0] d;
        d = 4'd0;
        for (int i = 0; i < NDIG; i++)
        begin
            d = bcd_reg[i*4 +: 4];
            bcd_adj[i*4 +: 4] = (d >= 4'd5) ? d + 4'd3 : d;
        end
    end

    // Next values of the conversion and bit-packing registers.
    always_comb
    begin
        bin_next     = bin_reg;
        bcd_next     = bcd_reg;
        bit_cnt_next = bit_cnt_reg;
        dig_cnt_next = dig_cnt_reg;
        acc_next     = acc_reg;
        cnt_next     = cnt_reg;
        remain_next  = remain_reg;
        active_next  = active_reg;

        if (cmd.load_start)
        begin
            bin_next     = block_length;
            bcd_next     = '0;
            bit_cnt_next = BCW'(LENGTH_BITS);
            dig_cnt_next = DCW'(NDIG);
            acc_next     = 12'd0;
            cnt_next     = 4'd0;
            remain_next  = block_length;
            active_next  = |block_length;
        end
        if (cmd.conv_step)
        begin
            bcd_next     = {bcd_adj[BCDW-2:0], bin_reg[LENGTH_BITS-1]};
            bin_next     = bin_reg << 1;
            bit_cnt_next = bit_cnt_reg - 1'b1;
        end
        if (cmd.digit_shift)
        begin
            bcd_next     = bcd_reg << 4;
            dig_cnt_next = dig_cnt_reg - 1'b1;
        end
        if (cmd.load_data)
        begin
            acc_next    = {8'd0, acc_reg[3:0]} | ({4'd0, data_byte} << cnt_reg[2:0]);
            cnt_next    = cnt_reg + 4'd8;
            remain_next = remain_reg - 1'b1;
        end
        if (cmd.group_shift)
        begin
            acc_next = acc_reg >> 6;
            cnt_next = cnt_reg - 4'd6;
        end
        if (cmd.close_block)
        begin
            acc_next    = 12'd0;
            cnt_next    = 4'd0;
            active_next = 1'b0;
        end
    end

    // Output word register; it frees when the word is taken.
    always_comb
    begin
        out_char_next  = out_char_reg;
        is_last_next   = is_last_reg;
        out_valid_next = out_valid_reg & out_stall;
        case (cmd.emit_sel)
            EMIT_DIGIT:
            begin
                out_char_next = CHAR_ZERO | {3'd0, top_digit};
            end
            EMIT_DOT:
            begin
                out_char_next = CHAR_DOT;
            end
            EMIT_ALPHA:
            begin
                out_char_next = alpha_char(acc_reg[5:0]);
            end
            default:
            begin
                out_char_next = out_char_reg;
            end
        endcase
        if (cmd.emit_sel != EMIT_NONE)
        begin
            is_last_next   = cmd.emit_last;
            out_valid_next = 1'b1;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= 12'd0;
            cnt_reg       <= 4'd0;
            remain_reg    <= '0;
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            acc_reg       <= acc_next;
            cnt_reg       <= cnt_next;
            remain_reg    <= remain_next;
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        bin_reg      <= bin_next;
        bcd_reg      <= bcd_next;
        bit_cnt_reg  <= bit_cnt_next;
        dig_cnt_reg  <= dig_cnt_next;
        out_char_reg <= out_char_next;
        is_last_reg  <= is_last_next;
    end

    // Status back to the controller.
    always_comb
    begin
        sts.active     = active_reg;
        sts.rem_zero   = (remain_reg == '0);
        sts.cnt_is12   = (cnt_reg == 4'd12);
        sts.cnt_is6    = (cnt_reg == 4'd6);
        sts.top_zero   = (top_digit == 4'd0);
        sts.conv_last  = (bit_cnt_reg == BCW'(1));
        sts.digit_last = (dig_cnt_reg == DCW'(1));
        sts.out_free   = !out_valid_reg || !out_stall;
    end

    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign is_last   = is_last_reg;

`ifndef ASSERT_OFF
    // The bit buffer never holds more than two groups, always an even count.
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg <= 4'd12) && !cnt_reg[0])
        else $error("bit buffer count out of range");

    // With no block open, no leftover bits remain.
    a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !active_reg |-> (cnt_reg == 4'd0))
        else $error("leftover bits held while no block is open");

    // A loaded word is shown as valid in the next cycle.
    a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_sel != EMIT_NONE) |=> out_valid_reg)
        else $error("emitted word not presented");
`endif

endmodule

`default_nettype wire

[rtl/lfr64_ctrl.sv]
`default_nettype none

module lfr64_ctrl
    import lfr64_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    input  wire logic       op,
    input  wire lfr64_sts_t sts,
    output lfr64_cmd_t      cmd,
    output logic            in_stall
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CONV = 3'd1;
    localparam logic [2:0] S_DIG  = 3'd2;
    localparam logic [2:0] S_DOT  = 3'd3;
    localparam logic [2:0] S_EMIT = 3'd4;
    localparam logic [2:0] S_PAD  = 3'd5;

    logic [2:0] state_reg, state_next;
    logic       started_reg, started_next;

    // A new word is taken only in the idle state.
    assign in_stall = (state_reg != S_IDLE);

    // Sequencing of conversion, digit output and character output.
    always_comb
    begin
        cmd          = '0;
        state_next   = state_reg;
        started_next = started_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (op == OP_START)
                    begin
                        cmd.load_start = 1'b1;
                        started_next   = 1'b0;
                        state_next     = S_CONV;
                    end
                    else if (sts.active)
                    begin
                        cmd.load_data = 1'b1;
                        state_next    = S_EMIT;
                    end
                end
            end
            S_CONV:
            begin
                cmd.conv_step = 1'b1;
                if (sts.conv_last)
                begin
                    state_next = S_DIG;
                end
            end
            S_DIG:
            begin
                // Leading zeros are dropped, but the last digit always goes out.
                if (!started_reg && sts.top_zero && !sts.digit_last)
                begin
                    cmd.digit_shift = 1'b1;
                end
                else if (sts.out_free)
                begin
                    cmd.emit_sel    = EMIT_DIGIT;
                    cmd.digit_shift = 1'b1;
                    started_next    = 1'b1;
                    if (sts.digit_last)
                    begin
                        state_next = S_DOT;
                    end
                end
            end
            S_DOT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_sel  = EMIT_DOT;
                    cmd.emit_last = !sts.active;
                    state_next    = S_IDLE;
                end
            end
            S_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_sel    = EMIT_ALPHA;
                    cmd.group_shift = 1'b1;
                    cmd.emit_last   = sts.rem_zero && sts.cnt_is6;
                    if (sts.cnt_is12)
                    begin
                        state_next = S_EMIT;
                    end
                    else if (sts.cnt_is6)
                    begin
                        cmd.close_block = sts.rem_zero;
                        state_next      = S_IDLE;
                    end
                    else if (sts.rem_zero)
                    begin
                        state_next = S_PAD;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_PAD:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_sel    = EMIT_ALPHA;
                    cmd.emit_last   = 1'b1;
                    cmd.close_block = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            started_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            started_reg <= started_next;
        end
    end

`ifndef ASSERT_OFF
    // Nothing is written to the output register while it still holds a word.
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_sel != EMIT_NONE) |-> sts.out_free)
        else $error("output word overwritten");

    // An accepted byte of an open block always leads to character output.
    a_data_path: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && in_valid && op && sts.active) |=> (state_reg == S_EMIT))
        else $error("data byte of an open block not encoded");
`endif

endmodule

`default_nettype wire

[rtl/lsb_first_radix64_encoder.sv]
// A start word runs the double-dabble conversion over all LENGTH_BITS bits, then steps through
// each decimal digit position and then writes the '.'.
// A data byte is accepted, then each character it yields is written out in turn.
// One word at a time runs through the shared double-dabble and bit-packing datapath.
// A stalled output holds the sequencer wherever it must write a character; the output word register is one deep.
// Reset (rst_n, asynchronous, active low) closes any open block and empties the output.
`default_nettype none

module lsb_first_radix64_encoder
    import lfr64_pkg::*;
#(
    parameter int LENGTH_BITS = 24
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic                   op,
    input  wire logic [LENGTH_BITS-1:0] block_length,
    input  wire logic [7:0]             data_byte,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic [6:0]                  out_char,
    output logic                        is_last
);

    lfr64_cmd_t cmd;
    lfr64_sts_t sts;

    // Sequencer.
    lfr64_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .op       (op),
        .sts      (sts),
        .cmd      (cmd),
        .in_stall (in_stall)
    );

    // Conversion, packing and output register.
    lfr64_dpath #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .block_length (block_length),
        .data_byte    (data_byte),
        .out_stall    (out_stall),
        .cmd          (cmd),
        .sts          (sts),
        .out_valid    (out_valid),
        .out_char     (out_char),
        .is_last      (is_last)
    );

endmodule

`default_nettype wire

[tb/lsb_first_radix64_encoder_tb.sv]
`timescale 1ns / 100ps

module lsb_first_radix64_encoder_tb;

    import lfr64_pkg::*;

    localparam int RUN_LIMIT  = 600000;
    localparam int MAX_REPORT = 10;

    // Running model of the encoder plus the queue of characters still owed by the block.
    class encoder_scoreboard;
        typedef struct {
            bit [6:0] ch;
            bit       last;
        } enc_char_t;

        enc_char_t expected_chars[$];
        string     symbols = ".ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+";
        bit [3:0]  spare_bits;
        bit [2:0]  spare_count;
        bit [23:0] bytes_left;
        bit        in_block;
        int        mismatches;
        int        checked;

        function void push_char(bit [6:0] ch, bit last);
            enc_char_t item;
            item.ch   = ch;
            item.last = last;
            expected_chars.push_back(item);
        endfunction

        function bit [6:0] symbol_of(bit [5:0] idx);
            bit [7:0] c;
            c = symbols[idx];
            return c[6:0];
        endfunction

        // Predicts the characters for one accepted word; returns 0 if the block ignores it.
        function bit note_word(bit op_bit, bit [23:0] len, bit [7:0] data_val);
            bit [6:0]  digits[$];
            bit [23:0] v;
            bit [23:0] digit;
            bit [11:0] acc;
            int        cnt;
            enc_char_t tail;
            if (op_bit == OP_START)
            begin
                // Decimal length, most significant digit first, then the separator.
                v = len;
                do
                begin
                    digit = v % 10;
                    digits.push_front(CHAR_ZERO + digit[6:0]);
                    v = v / 10;
                end
                while (v != 0);
                foreach (digits[i])
                begin
                    push_char(digits[i], 1'b0);
                end
                push_char(CHAR_DOT, len == 0);
                spare_bits  = '0;
                spare_count = '0;
                bytes_left  = len;
                in_block    = (len != 0);
                return 1'b1;
            end
            if (!in_block)
            begin
                return 1'b0;
            end
            // New byte sits above the leftover bits; emit every full 6-bit group.
            acc = {8'b0, spare_bits} | ({4'b0, data_val} << spare_count);
            cnt = spare_count + 8;
            while (cnt >= 6)
            begin
                push_char(symbol_of(acc[5:0]), 1'b0);
                acc = acc >> 6;
                cnt = cnt - 6;
            end
            bytes_left = bytes_left - 1;
            if (bytes_left == 0)
            begin
                // Pad the remainder, or mark the last group if nothing is left over.
                if (cnt > 0)
                begin
                    push_char(symbol_of(acc[5:0]), 1'b1);
                end
                else
                begin
                    tail = expected_chars.pop_back();
                    tail.last = 1'b1;
                    expected_chars.push_back(tail);
                end
                spare_bits  = '0;
                spare_count = '0;
                in_block    = 1'b0;
            end
            else
            begin
                spare_bits  = acc[3:0];
                spare_count = cnt[2:0];
            end
            return 1'b1;
        endfunction

        // Compares one accepted output word with the oldest pending character.
        function void check_char(logic [6:0] ch, logic last);
            enc_char_t want;
            checked++;
            if (expected_chars.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORT)
                begin
                    $display("char %0d: unexpected out_char 0x%02h is_last %0b, none pending",
                             checked, ch, last);
                end
                return;
            end
            want = expected_chars.pop_front();
            if (want.ch !== ch || want.last !== last)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORT)
                begin
                    $display("char %0d: out_char exp 0x%02h got 0x%02h, is_last exp %0b got %0b",
                             checked, want.ch, ch, want.last, last);
                end
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        op;
    logic [23:0] block_length;
    logic [7:0]  data_byte;
    logic        out_valid;
    wire         out_stall;
    logic [6:0]  out_char;
    logic        is_last;

    logic        rx_pause;
    logic        long_hold;
    int          hold_len;
    bit          steady;
    int          cycles;
    int          counted;
    int          ignored;
    int          starts_sent;
    int          bytes_sent;

    encoder_scoreboard sb;

    assign out_stall = rx_pause | long_hold;

    lsb_first_radix64_encoder u_dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .op           (op),
        .block_length (block_length),
        .data_byte    (data_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_char     (out_char),
        .is_last      (is_last)
    );

    // Clock: 20 ns period.
    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    // Idle draw shared by both sides; steady stretches have no idling at all.
    function int draw_gap();
        if (steady || $urandom_range(0, 2) == 0)
        begin
            return 0;
        end
        return $urandom_range(0, 17);
    endfunction

    // Run limit.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > RUN_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycles);
            $display("Mismatches found");
            $finish;
        end
    end

    // Every accepted output word goes to the scoreboard.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            sb.check_char(out_char, is_last);
        end
    end

    // Receiver: random stall before taking each word.
    initial
    begin : rx_proc
        int gap;
        rx_pause = 1'b0;
        forever
        begin
            gap = draw_gap();
            @(negedge clk);
            rx_pause = (gap > 0);
            if (gap > 0)
            begin
                repeat (gap) @(negedge clk);
                rx_pause = 1'b0;
            end
            do @(posedge clk); while (!(rst_n && out_valid && !out_stall));
        end
    end

    // Long receiver hold-off, counted in cycles, on request from the stimulus.
    initial
    begin
        long_hold = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_len > 0)
            begin
                long_hold = 1'b1;
                repeat (hold_len) @(negedge clk);
                long_hold = 1'b0;
                hold_len = 0;
            end
        end
    end

    // Offers one word after a random gap and waits until it is taken.
    task automatic send_word(input bit op_bit, input bit [23:0] len, input bit [7:0] data_val);
        int gap;
        gap = draw_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid     = 1'b1;
        op           = op_bit;
        block_length = len;
        data_byte    = data_val;
        do @(posedge clk); while (in_stall);
        if (sb.note_word(op_bit, len, data_val))
        begin
            counted++;
        end
        else
        begin
            ignored++;
        end
    endtask

    task automatic send_start(input bit [23:0] len);
        starts_sent++;
        send_word(OP_START, len, 8'($urandom));
    endtask

    task automatic send_data(input bit [7:0] data_val);
        bytes_sent++;
        send_word(OP_DATA, 24'($urandom), data_val);
    endtask

    initial
    begin : stimulus
        bit [23:0] len;
        int        n;
        int        kind;
        bit        pressure_done;

        sb = new();
        cycles       = 0;
        counted      = 0;
        ignored      = 0;
        starts_sent  = 0;
        bytes_sent   = 0;
        hold_len     = 0;
        steady       = 1'b0;
        pressure_done = 1'b0;
        in_valid     = 1'b0;
        op           = OP_START;
        block_length = '0;
        data_byte    = '0;
        rst_n        = 1'b0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        // Directed: byte with no block, empty block, pad cases, group boundary,
        // longest length abandoned by a new start, and bytes beyond the length.
        send_data(8'hff);
        send_start(24'd0);
        send_start(24'd1);
        send_data(8'hff);
        send_start(24'd3);
        send_data(8'h00);
        send_data(8'hff);
        send_data(8'ha5);
        send_start(24'hffffff);
        send_data(8'h5a);
        send_data(8'hc3);
        send_start(24'd2);
        send_data(8'h01);
        send_data(8'h80);
        send_data(8'h77);
        send_start(24'd10);
        send_data(8'h3c);
        send_start(24'd5);
        send_data(8'h00);
        send_data(8'hff);
        send_data(8'h00);
        send_data(8'hff);
        send_data(8'h81);

        // Random blocks: mostly complete, some cut short, some with trailing bytes.
        while (counted < 420)
        begin
            steady = ($urandom_range(0, 3) == 0);
            if (!pressure_done && counted > 150)
            begin
                // Receiver holds off while the sender keeps the input busy.
                pressure_done = 1'b1;
                steady = 1'b1;
                hold_len = 400;
                send_start(24'd40);
                repeat (40) send_data(8'($urandom));
                continue;
            end
            kind = $urandom_range(0, 19);
            if (kind == 0)
            begin
                len = 24'd0;
            end
            else if (kind == 1)
            begin
                len = 24'($urandom);
            end
            else if (kind == 2)
            begin
                len = 24'($urandom_range(13, 60));
            end
            else
            begin
                len = 24'($urandom_range(1, 12));
            end
            send_start(len);
            kind = $urandom_range(0, 7);
            if (len > 60)
            begin
                n = $urandom_range(0, 6);
            end
            else if (kind == 0)
            begin
                n = $urandom_range(0, len);
            end
            else if (kind == 1)
            begin
                n = len + $urandom_range(1, 3);
            end
            else
            begin
                n = len;
            end
            repeat (n) send_data(8'($urandom));
        end
        @(negedge clk);
        in_valid = 1'b0;
        steady = 1'b0;

        // Drain, then give the block time to show any stray word.
        while (sb.expected_chars.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (60) @(posedge clk);

        $display("Sent %0d start words and %0d data bytes (%0d ignored by the block).",
                 starts_sent, bytes_sent, ignored);
        $display("Checked %0d output characters, %0d with errors.", sb.checked, sb.mismatches);
        if (sb.mismatches == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
